/* hw/rtl/kfc_pkg.sv */
// Shared types, sizes and status codes for the key frequency counting table.
package kfc_pkg;

  localparam int unsigned NUM_BUCKETS = 4096;
  localparam int unsigned WAYS        = 8;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned BKT_W   = $clog2(NUM_BUCKETS);
  localparam int unsigned FILL_W  = $clog2(WAYS + 1);
  localparam int unsigned WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W  = $clog2(QUEUE_DEPTH + 1);

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [STAT_W-1:0]  status_t;
  typedef logic [BKT_W-1:0]   bkt_t;
  typedef logic [FILL_W-1:0]  fill_t;
  typedef logic [WAY_W-1:0]   way_t;

  localparam count_t  COUNT_MAX = '1;
  localparam status_t STAT_HIT  = 2'd0;
  localparam status_t STAT_NEW  = 2'd1;
  localparam status_t STAT_FULL = 2'd2;

  typedef struct packed {
    key_t key;
    bkt_t bucket;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_out_t;

endpackage

/* hw/rtl/kfc_key_if.sv */
// Key channel: valid/ready handshake carrying one hashed key.
interface kfc_key_if;
  logic          valid;
  logic          ready;
  kfc_pkg::key_t key;

  modport source (output valid, output key, input ready);
  modport sink   (input valid, input key, output ready);
endinterface

/* hw/rtl/kfc_res_if.sv */
// Result channel: valid/ready handshake carrying count and status.
interface kfc_res_if;
  logic             valid;
  logic             ready;
  kfc_pkg::count_t  count;
  kfc_pkg::status_t status;

  modport source (output valid, output count, output status, input ready);
  modport sink   (input valid, input count, input status, output ready);
endinterface

/* hw/rtl/kfc_front.sv */
// Front end: accepts keys, derives the bucket and queues them for the back end.
module kfc_front (
  input  logic                clk,
  input  logic                rst_n,
  kfc_key_if.sink             in_ch,
  input  logic                clear_busy,
  output kfc_pkg::queue_out_t q_out,
  input  logic                q_pop
);

  kfc_pkg::item_t              q_mem_r [kfc_pkg::QUEUE_DEPTH];
  logic [kfc_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [kfc_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [kfc_pkg::QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        push;
  kfc_pkg::item_t              new_item;

  assign in_ch.ready = !clear_busy && (cnt_r != kfc_pkg::QCNT_W'(kfc_pkg::QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    new_item.key    = in_ch.key;
    new_item.bucket = in_ch.key[kfc_pkg::BKT_W-1:0];
  end

  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_item;
    end
  end

  assign q_out.valid = (cnt_r != '0);
  assign q_out.item  = q_mem_r[rd_ptr_r];

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> cnt_r != '0)
    else $error("pop from empty queue");

  a_no_push_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear_busy |-> !push)
    else $error("key transfer during clearing pass");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= kfc_pkg::QCNT_W'(kfc_pkg::QUEUE_DEPTH))
    else $error("queue count overflow");

endmodule

/* hw/rtl/kfc_back.sv */
// Back end: bucket memories, clearing pass, lookup/update and result register.
module kfc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  kfc_pkg::queue_out_t q_in,
  output logic                q_pop,
  output logic                clear_busy,
  kfc_res_if.source           out_ch
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_LOOK  = 2'd2;

  kfc_pkg::key_t   key_mem  [kfc_pkg::NUM_BUCKETS][kfc_pkg::WAYS];
  kfc_pkg::count_t cnt_mem  [kfc_pkg::NUM_BUCKETS][kfc_pkg::WAYS];
  kfc_pkg::fill_t  fill_mem [kfc_pkg::NUM_BUCKETS];

  kfc_pkg::key_t   key_row_r [kfc_pkg::WAYS];
  kfc_pkg::count_t cnt_row_r [kfc_pkg::WAYS];
  kfc_pkg::fill_t  fill_rd_r;

  logic [1:0]       state_r, state_nxt;
  kfc_pkg::bkt_t    clr_idx_r, clr_idx_nxt;
  kfc_pkg::key_t    key_r, key_nxt;
  kfc_pkg::bkt_t    bkt_r, bkt_nxt;
  logic             out_valid_r, out_valid_nxt;
  kfc_pkg::count_t  out_count_r, out_count_nxt;
  kfc_pkg::status_t out_status_r, out_status_nxt;

  logic               rd_en;
  logic               key_we, cnt_we, fill_we;
  kfc_pkg::way_t      cnt_wa, new_way;
  kfc_pkg::count_t    cnt_wd;
  kfc_pkg::bkt_t      fill_wa;
  kfc_pkg::fill_t     fill_wd;
  logic               out_free;
  logic [kfc_pkg::WAYS-1:0] match;
  logic               hit, full;
  kfc_pkg::way_t      hit_way;
  kfc_pkg::count_t    cnt_sel, cnt_inc;

  assign out_free = !out_valid_r || out_ch.ready;
  assign new_way  = fill_rd_r[kfc_pkg::WAY_W-1:0];
  assign full     = (fill_rd_r == kfc_pkg::FILL_W'(kfc_pkg::WAYS));

  always_comb begin
    for (int w = 0; w < kfc_pkg::WAYS; w++) begin
      match[w] = (kfc_pkg::FILL_W'(w) < fill_rd_r) && (key_row_r[w] == key_r);
    end
    hit     = |match;
    hit_way = '0;
    for (int w = kfc_pkg::WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = kfc_pkg::WAY_W'(w);
      end
    end
    cnt_sel = cnt_row_r[hit_way];
    cnt_inc = (cnt_sel == kfc_pkg::COUNT_MAX) ? cnt_sel : cnt_sel + 1'b1;
  end

  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    key_nxt        = key_r;
    bkt_nxt        = bkt_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    rd_en          = 1'b0;
    q_pop          = 1'b0;
    key_we         = 1'b0;
    cnt_we         = 1'b0;
    fill_we        = 1'b0;
    cnt_wa         = new_way;
    cnt_wd         = kfc_pkg::COUNT_W'(1);
    fill_wa        = bkt_r;
    fill_wd        = fill_rd_r + 1'b1;
    case (state_r)
      S_CLEAR: begin
        fill_we     = 1'b1;
        fill_wa     = clr_idx_r;
        fill_wd     = '0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == kfc_pkg::BKT_W'(kfc_pkg::NUM_BUCKETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_in.valid) begin
          q_pop     = 1'b1;
          rd_en     = 1'b1;
          key_nxt   = q_in.item.key;
          bkt_nxt   = q_in.item.bucket;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (hit) begin
            cnt_we         = 1'b1;
            cnt_wa         = hit_way;
            cnt_wd         = cnt_inc;
            out_count_nxt  = cnt_inc;
            out_status_nxt = kfc_pkg::STAT_HIT;
          end else if (full) begin
            out_count_nxt  = '0;
            out_status_nxt = kfc_pkg::STAT_FULL;
          end else begin
            key_we         = 1'b1;
            cnt_we         = 1'b1;
            fill_we        = 1'b1;
            out_count_nxt  = kfc_pkg::COUNT_W'(1);
            out_status_nxt = kfc_pkg::STAT_NEW;
          end
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    bkt_r        <= bkt_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[bkt_r][new_way] <= key_r;
    end
    if (rd_en) begin
      key_row_r <= key_mem[q_in.item.bucket];
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[bkt_r][cnt_wa] <= cnt_wd;
    end
    if (rd_en) begin
      cnt_row_r <= cnt_mem[q_in.item.bucket];
    end
  end

  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[fill_wa] <= fill_wd;
    end
    if (rd_en) begin
      fill_rd_r <= fill_mem[q_in.item.bucket];
    end
  end

  assign clear_busy    = (state_r == S_CLEAR);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.count  = out_count_r;
  assign out_ch.status = out_status_r;

  a_no_read_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !rd_en && !key_we && !cnt_we)
    else $error("bucket access during clearing pass");

  a_look_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOK && out_free) |=> out_valid_r && state_r == S_IDLE)
    else $error("lookup did not produce a result");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == kfc_pkg::STAT_FULL) |-> out_count_r == '0)
    else $error("dropped key with nonzero count");

  a_new_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == kfc_pkg::STAT_NEW) |-> out_count_r == kfc_pkg::COUNT_W'(1))
    else $error("inserted key with count other than one");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOK) |-> fill_rd_r <= kfc_pkg::FILL_W'(kfc_pkg::WAYS))
    else $error("bucket fill beyond way count");

endmodule

/* hw/rtl/key_frequency_counting_table.sv */
// Key frequency counting table: one 64-bit hashed key in, its updated count and status out.
// Each key leaves the two-entry input queue for the back end: the idle state reads the
// whole bucket row (keys, counts, fill) into registers, then the lookup state, once the
// output is free, compares all ways, writes the incremented or new entry back (a key for a
// full bucket is dropped) and loads the result register; only then does the back end take
// its next key. After reset no key is accepted while fill is cleared one bucket per cycle.
module key_frequency_counting_table (
  input  logic       clk,
  input  logic       rst_n,
  kfc_key_if.sink    in_ch,
  kfc_res_if.source  out_ch
);

  kfc_pkg::queue_out_t q_out;
  logic                q_pop;
  logic                clear_busy;

  kfc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .clear_busy (clear_busy),
    .q_out      (q_out),
    .q_pop      (q_pop)
  );

  kfc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_in       (q_out),
    .q_pop      (q_pop),
    .clear_busy (clear_busy),
    .out_ch     (out_ch)
  );

endmodule
